FILE: sv/sliding_min_tophat_feature_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding-minimum top-hat feature block
// Concurrent check wrappers, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MIN_TOPHAT_FEATURE_ASSERT_SVH
`define SLIDING_MIN_TOPHAT_FEATURE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMTF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smtf check failed");

// next-cycle implication
`define SMTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smtf check failed");

`else

`define SMTF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SMTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/smtf_pkg.sv
// ----------------------------------------------------------------------------
// smtf_pkg
// Shared widths, limits and types for the sliding-minimum top-hat feature.
// ----------------------------------------------------------------------------
`default_nettype none

package smtf_pkg;

    // window derivation: sampling rate times R-wave width, plus one
    localparam int FS_HZ          = 250;
    localparam int RWAVE_MS       = 30;
    localparam int MS_PER_S       = 1000;
    localparam int WINDOW_DEFAULT = FS_HZ * RWAVE_MS / MS_PER_S + 1;

    localparam int SAMPLE_W  = 16;
    localparam int TOPHAT_W  = SAMPLE_W + 1;   // sample minus minimum
    localparam int DIFF_W    = TOPHAT_W + 1;   // difference of two top-hat values
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int FEATURE_W = 33;

    // saturation limit, 65535 squared
    localparam logic signed [PROD_W-1:0]    PROD_MAX    = 36'sd4294836225;
    localparam logic signed [PROD_W-1:0]    PROD_MIN    = -36'sd4294836225;
    localparam logic signed [FEATURE_W-1:0] FEATURE_MAX = 33'sd4294836225;
    localparam logic signed [FEATURE_W-1:0] FEATURE_MIN = -33'sd4294836225;

    // top-hat differences handed to the product stage
    typedef struct packed {
        logic signed [DIFF_W-1:0] d_old;   // t[j-W] - t[j-2W]
        logic signed [DIFF_W-1:0] d_new;   // t[j-W] - t[j]
    } smtf_diff_t;

endpackage

`default_nettype wire

FILE: sv/smtf_if.sv
// ----------------------------------------------------------------------------
// smtf channel interfaces
// Valid/ready channels for ECG samples in and feature values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smtf_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [smtf_pkg::SAMPLE_W-1:0]     sample;
    logic                                     is_last;

    modport source (output valid, sample, is_last, input ready);
    modport sink   (input valid, sample, is_last, output ready);
endinterface

interface smtf_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [smtf_pkg::FEATURE_W-1:0]    feature;

    modport source (output valid, feature, input ready);
    modport sink   (input valid, feature, output ready);
endinterface

`default_nettype wire

FILE: sv/smtf_tophat.sv
// ----------------------------------------------------------------------------
// smtf_tophat
// Sliding minimum, top-hat value, top-hat history and difference register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_min_tophat_feature_assert.svh"

module smtf_tophat #(
    parameter int WINDOW = smtf_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    input  wire logic signed [smtf_pkg::SAMPLE_W-1:0] item_sample,
    input  wire logic                                 item_last,
    output logic                                      item_ready,
    output logic                                      diff_valid,
    output smtf_pkg::smtf_diff_t                      diff,
    input  wire logic                                 diff_ready
);
    import smtf_pkg::*;

    localparam int TH_DEPTH = 2 * WINDOW;
    localparam int CNT_W    = $clog2(TH_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_WIN  = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TH_DEPTH);

    // history shift lines, index 0 newest
    logic signed [SAMPLE_W-1:0] hist_reg [WINDOW];
    logic signed [TOPHAT_W-1:0] th_reg   [TH_DEPTH];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       diff_valid_reg;
    logic                       diff_valid_next;
    smtf_diff_t                 diff_reg;
    smtf_diff_t                 diff_next;

    logic                       take;
    logic                       emit;
    logic signed [SAMPLE_W-1:0] min_all;
    logic signed [SAMPLE_W-1:0] min_last;
    logic signed [TOPHAT_W-1:0] t_val;
    logic signed [TOPHAT_W-1:0] t_cur;
    logic signed [TOPHAT_W-1:0] th_mid;
    logic signed [TOPHAT_W-1:0] th_old;

    assign item_ready = !diff_valid_reg || diff_ready;
    assign take       = item_valid && item_ready;
    assign diff_valid = diff_valid_reg;
    assign diff       = diff_reg;

    // window minima: full history, and history without its oldest plus the new sample
    always_comb
    begin
        min_all  = hist_reg[0];
        min_last = item_sample;
        for (int i = 1; i < WINDOW; i++)
        begin
            if (hist_reg[i] < min_all)
                min_all = hist_reg[i];
        end
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            if (hist_reg[i] < min_last)
                min_last = hist_reg[i];
        end
    end

    // top-hat values and differences
    always_comb
    begin
        t_val  = TOPHAT_W'(item_sample) - TOPHAT_W'(min_all);
        t_cur  = item_last ? (TOPHAT_W'(item_sample) - TOPHAT_W'(min_last)) : t_val;
        th_mid = th_reg[WINDOW-1];
        th_old = th_reg[TH_DEPTH-1];
        emit   = (count_reg == CNT_FULL);
        diff_next.d_old = DIFF_W'(th_mid) - DIFF_W'(th_old);
        diff_next.d_new = DIFF_W'(th_mid) - DIFF_W'(t_cur);
    end

    // record position, saturating; cleared after the final sample
    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            priority if (item_last)
                count_next = '0;
            else if (count_reg < CNT_FULL)
                count_next = count_reg + CNT_W'(1);
            else
                count_next = count_reg;
        end
    end

    always_comb
    begin
        diff_valid_next = diff_valid_reg;
        priority if (take)
            diff_valid_next = emit;
        else if (diff_ready)
            diff_valid_next = 1'b0;
        else
            diff_valid_next = diff_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            diff_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            diff_valid_reg <= diff_valid_next;
        end
    end

    // histories and difference payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hist_reg[0] <= item_sample;
            for (int i = 1; i < WINDOW; i++)
                hist_reg[i] <= hist_reg[i-1];

            if (count_reg == CNT_WIN)
            begin
                // first top-hat value stands in for all earlier ones
                for (int i = 0; i < TH_DEPTH; i++)
                    th_reg[i] <= t_val;
            end
            else if (count_reg > CNT_WIN)
            begin
                th_reg[0] <= t_val;
                for (int i = 1; i < TH_DEPTH; i++)
                    th_reg[i] <= th_reg[i-1];
            end

            diff_reg <= diff_next;
        end
    end

    `SMTF_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `SMTF_ASSERT_NEXT(a_last_clears, clk, rst_n, take && item_last, count_reg == '0)
    `SMTF_ASSERT_NEXT(a_fill_even, clk, rst_n, take && !item_last && count_reg == CNT_WIN,
        th_reg[0] == th_reg[TH_DEPTH-1])

endmodule

`default_nettype wire

FILE: sv/smtf_product.sv
// ----------------------------------------------------------------------------
// smtf_product
// Multiplies the two top-hat differences, saturates and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_min_tophat_feature_assert.svh"

module smtf_product (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               diff_valid,
    input  wire smtf_pkg::smtf_diff_t diff,
    output logic                    diff_ready,
    smtf_out_if.source              feature_ch
);
    import smtf_pkg::*;

    logic                        feat_valid_reg;
    logic                        feat_valid_next;
    logic signed [FEATURE_W-1:0] feature_reg;
    logic signed [FEATURE_W-1:0] feature_next;
    logic signed [PROD_W-1:0]    prod;
    logic                        take;

    assign diff_ready         = !feat_valid_reg || feature_ch.ready;
    assign take               = diff_valid && diff_ready;
    assign feature_ch.valid   = feat_valid_reg;
    assign feature_ch.feature = feature_reg;

    // full-width product, clamped to the feature range
    always_comb
    begin
        prod = diff.d_old * diff.d_new;
        priority if (prod > PROD_MAX)
            feature_next = FEATURE_MAX;
        else if (prod < PROD_MIN)
            feature_next = FEATURE_MIN;
        else
            feature_next = prod[FEATURE_W-1:0];
    end

    always_comb
    begin
        feat_valid_next = feat_valid_reg;
        priority if (take)
            feat_valid_next = 1'b1;
        else if (feature_ch.ready)
            feat_valid_next = 1'b0;
        else
            feat_valid_next = feat_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            feat_valid_reg <= 1'b0;
        else
            feat_valid_reg <= feat_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            feature_reg <= feature_next;
    end

    `SMTF_ASSERT_IMPLY(a_feature_range, clk, rst_n, feat_valid_reg,
        feature_reg <= FEATURE_MAX && feature_reg >= FEATURE_MIN)

endmodule

`default_nettype wire

FILE: sv/sliding_min_tophat_feature.sv
// ----------------------------------------------------------------------------
// sliding_min_tophat_feature
// Streaming ECG top-hat feature: sample register, top-hat stage, product stage.
// ----------------------------------------------------------------------------
// One sample is taken per transfer and the block sustains one sample per
// clock while the feature side does not stall; a feature passes the input,
// difference and result registers after its sample is accepted. The pace
// is set by the top-hat stage, where the window minimum and the history
// update for one sample complete before the next sample reads them. Samples
// below index 2*WINDOW in a record give no feature; is_last ends the record.
// Stalls on the feature side hold each stage in turn back to the sample side.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_min_tophat_feature #(
    parameter int WINDOW = smtf_pkg::WINDOW_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    smtf_in_if.sink     sample_ch,
    smtf_out_if.source  feature_ch
);
    import smtf_pkg::*;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;
    logic                       stage_ready;
    logic                       in_take;
    logic                       diff_valid;
    logic                       diff_ready;
    smtf_diff_t                 diff;

    assign sample_ch.ready = !in_valid_reg || stage_ready;
    assign in_take         = sample_ch.valid && sample_ch.ready;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        priority if (in_take)
            in_valid_next = 1'b1;
        else if (stage_ready)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg <= sample_ch.sample;
            in_last_reg   <= sample_ch.is_last;
        end
    end

    // top-hat stage
    smtf_tophat #(
        .WINDOW (WINDOW)
    ) u_tophat (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item_sample (in_sample_reg),
        .item_last   (in_last_reg),
        .item_ready  (stage_ready),
        .diff_valid  (diff_valid),
        .diff        (diff),
        .diff_ready  (diff_ready)
    );

    // product stage and result register
    smtf_product u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .diff_valid (diff_valid),
        .diff       (diff),
        .diff_ready (diff_ready),
        .feature_ch (feature_ch)
    );

endmodule

`default_nettype wire
